// ===== rtl/crlc_pkg.sv =====
// Package for the reply line classifier: reply kinds, prefix tables, character codes.
// Used by crlc_out_if and by cnc_reply_line_classifier. No dependencies.
package crlc_pkg;

  localparam int STATE_BYTES = 8;
  localparam int NAME_W      = 8 * STATE_BYTES;
  localparam int TEXT_W      = 64;
  localparam int NUM_PREFIX  = 10;
  localparam int PFX_MAX_LEN = 6;

  typedef enum logic [2:0] {
    KIND_UNKNOWN = 3'd0,
    KIND_OK      = 3'd1,
    KIND_ERROR   = 3'd2,
    KIND_ALARM   = 3'd3,
    KIND_STATUS  = 3'd4,
    KIND_INFO    = 3'd5
  } reply_kind_t;

  // Prefix slots; the info prefixes occupy a contiguous range.
  localparam int PFX_OK         = 0;
  localparam int PFX_ERROR      = 1;
  localparam int PFX_ALARM      = 2;
  localparam int PFX_BANNER     = 3;
  localparam int PFX_INFO_FIRST = 4;
  localparam int PFX_INFO_LAST  = 8;
  localparam int PFX_STATUS     = 9;

  // Lower-case prefix text; the "ok" slot is compared case-sensitively.
  localparam logic [7:0] PFX_TEXT [NUM_PREFIX][PFX_MAX_LEN] = '{
    '{8'h6F, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h00},  // ok
    '{8'h65, 8'h72, 8'h72, 8'h6F, 8'h72, 8'h3A},  // error:
    '{8'h61, 8'h6C, 8'h61, 8'h72, 8'h6D, 8'h3A},  // alarm:
    '{8'h67, 8'h72, 8'h62, 8'h6C, 8'h20, 8'h00},  // banner word and a space
    '{8'h5B, 8'h6D, 8'h73, 8'h67, 8'h3A, 8'h00},  // [msg:
    '{8'h5B, 8'h67, 8'h63, 8'h3A, 8'h00, 8'h00},  // [gc:
    '{8'h5B, 8'h76, 8'h65, 8'h72, 8'h3A, 8'h00},  // [ver:
    '{8'h5B, 8'h6F, 8'h70, 8'h74, 8'h3A, 8'h00},  // [opt:
    '{8'h24, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // $
    '{8'h3C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}   // <
  };

  localparam logic [4:0] PFX_LEN [NUM_PREFIX] = '{
    5'd2, 5'd6, 5'd6, 5'd5, 5'd5, 5'd4, 5'd5, 5'd5, 5'd1, 5'd1
  };

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_GT    = 8'h3E;

  localparam logic [4:0]  POS_MAX  = 5'd31;
  localparam logic [16:0] CODE_SAT = 17'd32768;

endpackage

// ===== rtl/crlc_in_if.sv =====
// Input channel of the reply line classifier: one received character per item.
// Depends on nothing but the valid/ready handshake convention.
interface crlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       line_end;

  modport source (output valid, data_byte, byte_present, line_end, input ready);
  modport sink   (input valid, data_byte, byte_present, line_end, output ready);
endinterface

// ===== rtl/crlc_out_if.sv =====
// Output channel of the reply line classifier: one classification per item.
// Depends on crlc_pkg for the reply kind type and the text width.
interface crlc_out_if;
  logic                      valid;
  logic                      ready;
  crlc_pkg::reply_kind_t     reply_kind;
  logic signed [15:0]        reply_code;
  logic [crlc_pkg::TEXT_W-1:0] state_text;
  logic [3:0]                state_length;
  logic                      state_truncated;

  modport source (output valid, reply_kind, reply_code, state_text, state_length,
                  state_truncated, input ready);
  modport sink   (input valid, reply_kind, reply_code, state_text, state_length,
                  state_truncated, output ready);
endinterface

// ===== rtl/cnc_reply_line_classifier.sv =====
// Reply line classifier: input register, per-character line state, result register.
// Depends on crlc_pkg, crlc_in_if and crlc_out_if.
//
//   channel  | direction | item
//   ---------+-----------+-------------------------------------------------
//   in_ch    | sink      | data_byte, byte_present, line_end
//   out_ch   | source    | reply_kind, reply_code, state_text,
//            |           | state_length, state_truncated
//
// One item per cycle is taken unless a line end is held for a full result register.
// An accepted item is held in the input register, then updates the line state; an
// item that ends the line writes the result register as it leaves the input
// register. Reset (rst, synchronous) empties both registers and puts the line
// state in its idle form. A stalled output only holds back an item that ends a
// line while the result register is still full; characters ahead of it keep flowing.
module cnc_reply_line_classifier (
  input  logic          clk,
  input  logic          rst,
  crlc_in_if.sink       in_ch,
  crlc_out_if.source    out_ch
);
  import crlc_pkg::*;

  // Phases of the atoi-style code reader that runs after the colon.
  typedef enum logic [1:0] {
    CODE_SKIP   = 2'd0,
    CODE_SIGN   = 2'd1,
    CODE_DIGITS = 2'd2,
    CODE_DONE   = 2'd3
  } code_phase_t;

  // Input register.
  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_present;
  logic       s_end;

  // Line state.
  logic              seen_text;
  logic [4:0]        char_position;
  logic [4:0]        last_text_position;
  logic [NUM_PREFIX-1:0] prefix_alive;
  logic              banner_has_tail;
  code_phase_t       code_phase;
  logic              code_negative;
  logic [16:0]       code_accum;
  logic [NAME_W-1:0] name_bytes;
  logic [4:0]        name_length_bar;
  logic [4:0]        name_length_gt;
  logic [1:0]        delimiter_flags;

  // Line state after the current character has been folded in.
  logic              seen_text_next;
  logic [4:0]        char_position_next;
  logic [4:0]        last_text_position_next;
  logic [NUM_PREFIX-1:0] prefix_alive_next;
  logic              banner_has_tail_next;
  code_phase_t       code_phase_next;
  logic              code_negative_next;
  logic [16:0]       code_accum_next;
  logic [NAME_W-1:0] name_bytes_next;
  logic [4:0]        name_length_bar_next;
  logic [4:0]        name_length_gt_next;
  logic [1:0]        delimiter_flags_next;

  // Result candidates.
  reply_kind_t        kind_next;
  logic signed [15:0] code_next;
  logic [TEXT_W-1:0]  text_next;
  logic [3:0]         length_next;
  logic               trunc_next;

  logic out_valid;
  logic out_free;
  logic s_go;
  logic in_take;

  // The input register drains unless it holds a line end and the result
  // register cannot take a new result this cycle.
  assign out_free    = !out_valid || out_ch.ready;
  assign s_go        = s_valid && (!s_end || out_free);
  assign in_ch.ready = !s_valid || s_go;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;

  // Character update. Leading whitespace is dropped entirely; once text has
  // started, every character advances the position so trailing whitespace is
  // only excluded through last_text_position.
  always_comb begin
    logic        sp;
    logic        active;
    logic        digit;
    logic [7:0]  low_byte;
    logic [18:0] acc_mul;
    logic [4:0]  p;

    sp       = (s_byte == CH_SPACE) || (s_byte >= CH_TAB && s_byte <= CH_CR);
    active   = s_present && (seen_text || !sp);
    digit    = (s_byte >= CH_ZERO) && (s_byte <= CH_NINE);
    low_byte = (s_byte >= CH_UP_A && s_byte <= CH_UP_Z) ? s_byte + 8'd32 : s_byte;
    acc_mul  = 19'(code_accum) * 19'd10 + {15'd0, s_byte[3:0]};
    p        = char_position;

    seen_text_next          = seen_text;
    char_position_next      = char_position;
    last_text_position_next = last_text_position;
    prefix_alive_next       = prefix_alive;
    banner_has_tail_next    = banner_has_tail;
    code_phase_next         = code_phase;
    code_negative_next      = code_negative;
    code_accum_next         = code_accum;
    name_bytes_next         = name_bytes;
    name_length_bar_next    = name_length_bar;
    name_length_gt_next     = name_length_gt;
    delimiter_flags_next    = delimiter_flags;

    if (active) begin
      seen_text_next = 1'b1;
      if (!sp) begin
        last_text_position_next = p;
      end

      for (int k = 0; k < NUM_PREFIX; k++) begin
        if (p < PFX_LEN[k]) begin
          if (k == PFX_OK) begin
            if (s_byte != PFX_TEXT[k][p[2:0]]) begin
              prefix_alive_next[k] = 1'b0;
            end
          end else if (low_byte != PFX_TEXT[k][p[2:0]]) begin
            prefix_alive_next[k] = 1'b0;
          end
        end
      end

      // The banner's trailing space only counts when real text follows it.
      if (p >= 5'd5 && !sp) begin
        banner_has_tail_next = 1'b1;
      end

      // Code reader: everything from the seventh character on.
      if (p >= 5'd6 && code_phase != CODE_DONE) begin
        if (digit) begin
          code_accum_next = (acc_mul > 19'(CODE_SAT)) ? CODE_SAT : acc_mul[16:0];
          code_phase_next = CODE_DIGITS;
        end else if (code_phase == CODE_SKIP && sp) begin
          code_phase_next = CODE_SKIP;
        end else if (code_phase == CODE_SKIP && (s_byte == CH_PLUS || s_byte == CH_MINUS)) begin
          code_negative_next = (s_byte == CH_MINUS);
          code_phase_next    = CODE_SIGN;
        end else begin
          code_phase_next = CODE_DONE;
        end
      end

      // State name bytes follow the '<' until the first bar.
      for (int i = 0; i < STATE_BYTES; i++) begin
        if (!delimiter_flags[0] && p == 5'(i + 1)) begin
          name_bytes_next[8*i +: 8] = s_byte;
        end
      end

      if (s_byte == CH_BAR && !delimiter_flags[0]) begin
        delimiter_flags_next[0] = 1'b1;
        name_length_bar_next    = (p != 5'd0) ? p - 5'd1 : 5'd0;
      end
      if (s_byte == CH_GT && !delimiter_flags[1]) begin
        delimiter_flags_next[1] = 1'b1;
        name_length_gt_next     = (p != 5'd0) ? p - 5'd1 : 5'd0;
      end

      char_position_next = (p < POS_MAX) ? p + 5'd1 : POS_MAX;
    end
  end

  // Classification of the line as it stands after the current character.
  always_comb begin
    logic [NUM_PREFIX-1:0] alive;
    logic [4:0]  nlen;
    logic        has_end;
    logic [NAME_W-1:0] masked;
    logic [16:0] neg_code;

    for (int k = 0; k < NUM_PREFIX; k++) begin
      alive[k] = prefix_alive_next[k] && (char_position_next >= PFX_LEN[k]);
    end

    nlen    = 5'd0;
    has_end = 1'b0;
    if (delimiter_flags_next[0]) begin
      nlen    = name_length_bar_next;
      has_end = 1'b1;
    end else if (delimiter_flags_next[1]) begin
      nlen    = name_length_gt_next;
      has_end = 1'b1;
    end

    neg_code    = 17'd0 - code_accum_next;
    kind_next   = KIND_UNKNOWN;
    code_next   = 16'sd0;
    text_next   = '0;
    length_next = 4'd0;
    trunc_next  = 1'b0;
    masked      = '0;

    if (alive[PFX_OK] && last_text_position_next == 5'd1) begin
      kind_next = KIND_OK;
    end else if (alive[PFX_ERROR] || alive[PFX_ALARM]) begin
      kind_next = alive[PFX_ERROR] ? KIND_ERROR : KIND_ALARM;
      if (code_negative_next) begin
        code_next = neg_code[15:0];
      end else if (code_accum_next > 17'd32767) begin
        code_next = 16'sd32767;
      end else begin
        code_next = code_accum_next[15:0];
      end
    end else if (alive[PFX_STATUS] && last_text_position_next >= 5'd2 && has_end &&
                 nlen >= 5'd1) begin
      kind_next   = KIND_STATUS;
      trunc_next  = nlen > 5'(STATE_BYTES);
      length_next = trunc_next ? 4'(STATE_BYTES) : nlen[3:0];
      for (int i = 0; i < STATE_BYTES; i++) begin
        if (4'(i) < length_next) begin
          masked[8*i +: 8] = name_bytes_next[8*i +: 8];
        end
      end
      text_next = TEXT_W'(masked);
    end else if ((alive[PFX_BANNER] && banner_has_tail_next) ||
                 (|alive[PFX_INFO_LAST:PFX_INFO_FIRST])) begin
      kind_next = KIND_INFO;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_take) begin
      s_valid <= 1'b1;
    end else if (s_go) begin
      s_valid <= 1'b0;
    end
    if (in_take) begin
      s_byte    <= in_ch.data_byte;
      s_present <= in_ch.byte_present;
      s_end     <= in_ch.line_end;
    end
  end

  // Line state: folds in each character and returns to idle after a line end.
  always_ff @(posedge clk) begin
    if (rst || (s_go && s_end)) begin
      seen_text          <= 1'b0;
      char_position      <= 5'd0;
      last_text_position <= 5'd0;
      prefix_alive       <= '1;
      banner_has_tail    <= 1'b0;
      code_phase         <= CODE_SKIP;
      code_negative      <= 1'b0;
      code_accum         <= 17'd0;
      name_bytes         <= '0;
      name_length_bar    <= 5'd0;
      name_length_gt     <= 5'd0;
      delimiter_flags    <= 2'b00;
    end else if (s_go) begin
      seen_text          <= seen_text_next;
      char_position      <= char_position_next;
      last_text_position <= last_text_position_next;
      prefix_alive       <= prefix_alive_next;
      banner_has_tail    <= banner_has_tail_next;
      code_phase         <= code_phase_next;
      code_negative      <= code_negative_next;
      code_accum         <= code_accum_next;
      name_bytes         <= name_bytes_next;
      name_length_bar    <= name_length_bar_next;
      name_length_gt     <= name_length_gt_next;
      delimiter_flags    <= delimiter_flags_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_go && s_end) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (s_go && s_end) begin
      out_ch.reply_kind      <= kind_next;
      out_ch.reply_code      <= code_next;
      out_ch.state_text      <= text_next;
      out_ch.state_length    <= length_next;
      out_ch.state_truncated <= trunc_next;
    end
  end

endmodule
